// ----- src/mnt_pkg.sv -----
// ----------------------------------------------------------------------------
// mnt_pkg
// shared types, constants and helpers of the missing sequence nack tracker
// ----------------------------------------------------------------------------
package mnt_pkg;

  // sequence numbers and the received bitmap
  localparam int SEQ_W      = 16;
  localparam int MAX_SEQ    = 65536;
  localparam int MAX_REPORT = 64;
  localparam int GROW_STEP  = 1000;

  // bitmap memory organisation: one word holds WORD_W consecutive flags
  localparam int WORD_W    = 32;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int MAP_WORDS = MAX_SEQ / WORD_W;
  localparam int ADDR_W    = $clog2(MAP_WORDS);
  localparam int CNT_W     = $clog2(MAX_REPORT + 1);

  // command queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_TOTAL_PACKETS = 1'b0;
  localparam logic [SEQ_W-1:0] TOTAL_RESET = 16'd1;

  // input mode codes
  localparam logic MODE_DATA  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [SEQ_W-1:0] seq_no;
  } in_item_t;

  typedef struct packed {
    logic [SEQ_W-1:0] missing_seq;
    logic             last;
    logic             done_res;
  } out_item_t;

  typedef struct packed {
    logic             is_query;
    logic [SEQ_W-1:0] seq_no;
    logic [SEQ_W-1:0] win_top;
    logic             complete;
  } cmd_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_DATA_WR,
    B_Q_LOAD,
    B_Q_SCAN,
    B_FINISH
  } back_state_t;

  // position of the lowest set bit of a word
  function automatic logic [BIT_W-1:0] lowest_one(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ----- src/mnt_front.sv -----
// ----------------------------------------------------------------------------
// mnt_front
// takes input transfers, tracks the highest sequence and the window top,
// and turns each transfer into a command for the back end
// ----------------------------------------------------------------------------
module mnt_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  mnt_pkg::in_item_t         in_data,
  input  logic [mnt_pkg::SEQ_W-1:0] total_packets,
  input  logic                      q_full,
  input  logic                      map_ready,
  output logic                      push,
  output mnt_pkg::cmd_t             push_cmd
);

  logic [mnt_pkg::SEQ_W-1:0] highest_seen;
  logic [mnt_pkg::SEQ_W-1:0] track_limit;
  logic [mnt_pkg::SEQ_W-1:0] window_top;
  logic [mnt_pkg::SEQ_W-1:0] target;
  logic [mnt_pkg::SEQ_W-1:0] window_top_next;
  logic [mnt_pkg::SEQ_W:0]   grown;
  logic                      is_query;

  assign in_ready = map_ready && !q_full;
  assign push     = in_valid && in_ready;
  assign is_query = (in_data.mode == mnt_pkg::MODE_QUERY);

  // new target: highest seen, or grown by a step (capped at the packet total) when it has stalled
  always_comb begin
    grown  = {1'b0, highest_seen} + (mnt_pkg::SEQ_W + 1)'(mnt_pkg::GROW_STEP);
    target = highest_seen;
    if (track_limit == highest_seen && highest_seen < total_packets) begin
      if (grown > {1'b0, total_packets}) begin
        target = total_packets;
      end else begin
        target = grown[mnt_pkg::SEQ_W-1:0];
      end
    end
    window_top_next = (target > window_top) ? target : window_top;
  end

  always_comb begin
    push_cmd.is_query = is_query;
    push_cmd.seq_no   = in_data.seq_no;
    push_cmd.win_top  = window_top_next;
    push_cmd.complete = (highest_seen == total_packets);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      highest_seen <= '0;
      track_limit  <= mnt_pkg::SEQ_W'(1);
      window_top   <= '0;
    end else if (push) begin
      if (is_query) begin
        track_limit <= target;
        window_top  <= window_top_next;
      end else if (in_data.seq_no > highest_seen) begin
        highest_seen <= in_data.seq_no;
      end
    end
  end

endmodule

// ----- src/mnt_queue.sv -----
// ----------------------------------------------------------------------------
// mnt_queue
// short command queue between front and back end
// ----------------------------------------------------------------------------
module mnt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mnt_pkg::cmd_t push_cmd,
  input  logic          pop,
  output mnt_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);

  mnt_pkg::cmd_t                entries [mnt_pkg::Q_DEPTH];
  logic [mnt_pkg::Q_PTR_W-1:0]  wr_ptr;
  logic [mnt_pkg::Q_PTR_W-1:0]  rd_ptr;
  logic [mnt_pkg::Q_CNT_W-1:0]  count;

  assign empty = (count == '0);
  assign full  = (count == mnt_pkg::Q_CNT_W'(mnt_pkg::Q_DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ----- src/mnt_back.sv -----
// ----------------------------------------------------------------------------
// mnt_back
// owns the received bitmap: clears it after reset, sets flags for data
// commands and walks it word by word for queries
// ----------------------------------------------------------------------------
module mnt_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  mnt_pkg::cmd_t      q_head,
  output logic               q_pop,
  output logic               map_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output mnt_pkg::out_item_t out_data
);

  localparam int SW = mnt_pkg::SEQ_W;
  localparam int AW = mnt_pkg::ADDR_W;
  localparam int BW = mnt_pkg::BIT_W;
  localparam int WW = mnt_pkg::WORD_W;
  localparam int CW = mnt_pkg::CNT_W;

  logic [WW-1:0] map_mem [mnt_pkg::MAP_WORDS];
  logic [WW-1:0] rd_data;
  logic [AW-1:0] mem_raddr;
  logic [AW-1:0] mem_waddr;
  logic [WW-1:0] mem_wdata;
  logic          mem_we;

  mnt_pkg::back_state_t state, state_next;
  logic [AW-1:0]        clr_addr, clr_addr_next;
  logic [AW-1:0]        word_addr, word_addr_next;
  logic [BW-1:0]        bit_sel, bit_sel_next;
  logic [AW-1:0]        last_word, last_word_next;
  logic [BW-1:0]        top_bit, top_bit_next;
  logic                 complete, complete_next;
  logic [WW-1:0]        scan_bits, scan_bits_next;
  logic                 held_v, held_v_next;
  logic [SW-1:0]        held_seq, held_seq_next;
  logic [CW-1:0]        rpt_cnt, rpt_cnt_next;
  logic                 out_valid_next;
  mnt_pkg::out_item_t   out_data_next;

  logic          out_free;
  logic [WW-1:0] hi_cut;
  logic [WW-1:0] allowed;
  logic [BW-1:0] found_idx;
  logic [SW-1:0] found_seq;
  logic [WW-1:0] bits_left;
  logic [CW-1:0] rpt_inc;

  assign map_ready = (state != mnt_pkg::B_CLEAR);
  assign out_free  = !out_valid || out_ready;

  // flags of the current word that lie inside 1..window top
  always_comb begin
    hi_cut  = {{(WW-1){1'b1}}, 1'b0} << top_bit;
    allowed = (word_addr == last_word) ? ~hi_cut : '1;
    if (word_addr == '0) begin
      allowed[0] = 1'b0;
    end
  end

  assign found_idx = mnt_pkg::lowest_one(scan_bits);
  assign found_seq = {word_addr, found_idx};
  assign bits_left = scan_bits & (scan_bits - 1'b1);
  assign rpt_inc   = rpt_cnt + 1'b1;

  always_comb begin
    state_next     = state;
    clr_addr_next  = clr_addr;
    word_addr_next = word_addr;
    bit_sel_next   = bit_sel;
    last_word_next = last_word;
    top_bit_next   = top_bit;
    complete_next  = complete;
    scan_bits_next = scan_bits;
    held_v_next    = held_v;
    held_seq_next  = held_seq;
    rpt_cnt_next   = rpt_cnt;
    out_valid_next = out_valid && !out_ready;
    out_data_next  = out_data;
    q_pop          = 1'b0;
    mem_raddr      = word_addr;
    mem_we         = 1'b0;
    mem_waddr      = word_addr;
    mem_wdata      = '0;

    unique case (state)
      mnt_pkg::B_CLEAR: begin
        mem_we        = 1'b1;
        mem_waddr     = clr_addr;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == '1) begin
          state_next = mnt_pkg::B_IDLE;
        end
      end

      mnt_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_head.is_query) begin
            last_word_next = q_head.win_top[SW-1:BW];
            top_bit_next   = q_head.win_top[BW-1:0];
            complete_next  = q_head.complete;
            word_addr_next = '0;
            mem_raddr      = '0;
            rpt_cnt_next   = '0;
            held_v_next    = 1'b0;
            if (q_head.win_top == '0) begin
              state_next = mnt_pkg::B_FINISH;
            end else begin
              state_next = mnt_pkg::B_Q_LOAD;
            end
          end else begin
            word_addr_next = q_head.seq_no[SW-1:BW];
            bit_sel_next   = q_head.seq_no[BW-1:0];
            mem_raddr      = q_head.seq_no[SW-1:BW];
            state_next     = mnt_pkg::B_DATA_WR;
          end
        end
      end

      mnt_pkg::B_DATA_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = word_addr;
        mem_wdata  = rd_data | (WW'(1) << bit_sel);
        state_next = mnt_pkg::B_IDLE;
      end

      mnt_pkg::B_Q_LOAD: begin
        scan_bits_next = ~rd_data & allowed;
        state_next     = mnt_pkg::B_Q_SCAN;
      end

      mnt_pkg::B_Q_SCAN: begin
        if (scan_bits == '0) begin
          if (word_addr == last_word) begin
            state_next = mnt_pkg::B_FINISH;
          end else begin
            word_addr_next = word_addr + 1'b1;
            mem_raddr      = word_addr + 1'b1;
            state_next     = mnt_pkg::B_Q_LOAD;
          end
        end else if (!held_v || out_free) begin
          // the held number is known not to be the last one
          if (held_v) begin
            out_valid_next            = 1'b1;
            out_data_next.missing_seq = held_seq;
            out_data_next.last        = 1'b0;
            out_data_next.done_res    = 1'b0;
          end
          held_v_next    = 1'b1;
          held_seq_next  = found_seq;
          scan_bits_next = bits_left;
          rpt_cnt_next   = rpt_inc;
          if (rpt_inc == CW'(mnt_pkg::MAX_REPORT)) begin
            state_next = mnt_pkg::B_FINISH;
          end
        end
      end

      mnt_pkg::B_FINISH: begin
        if (held_v) begin
          if (out_free) begin
            out_valid_next            = 1'b1;
            out_data_next.missing_seq = held_seq;
            out_data_next.last        = 1'b1;
            out_data_next.done_res    = 1'b0;
            held_v_next               = 1'b0;
            state_next                = mnt_pkg::B_IDLE;
          end
        end else if (complete) begin
          if (out_free) begin
            out_valid_next            = 1'b1;
            out_data_next.missing_seq = '0;
            out_data_next.last        = 1'b1;
            out_data_next.done_res    = 1'b1;
            state_next                = mnt_pkg::B_IDLE;
          end
        end else begin
          state_next = mnt_pkg::B_IDLE;
        end
      end

      default: begin
        state_next = mnt_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mnt_pkg::B_CLEAR;
      clr_addr  <= '0;
      held_v    <= 1'b0;
      rpt_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      held_v    <= held_v_next;
      rpt_cnt   <= rpt_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    word_addr <= word_addr_next;
    bit_sel   <= bit_sel_next;
    last_word <= last_word_next;
    top_bit   <= top_bit_next;
    complete  <= complete_next;
    scan_bits <= scan_bits_next;
    held_seq  <= held_seq_next;
    out_data  <= out_data_next;
  end

  // bitmap memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= map_mem[mem_raddr];
  end

endmodule

// ----- src/missing_sequence_nack_tracker.sv -----
// ----------------------------------------------------------------------------
// missing_sequence_nack_tracker
// receiver-side lost-packet tracker with a received bitmap and nack listing
// ----------------------------------------------------------------------------
// A data transfer (mode 0) marks its sequence number as received; a query
// transfer (mode 1) moves the tracked window and lists up to 64 missing
// numbers in ascending order, the final one flagged with last, or a single
// done result when nothing is missing and the transfer is complete. After
// reset the block clears all 2048 words of the bitmap memory (one 32-bit
// word a cycle) and holds in_ready low meanwhile; register writes are taken
// during that time. A data transfer takes a read and then a write of the
// single bitmap memory in the back end. A query loads and scans that memory
// word by word up to the window top, reporting the missing numbers of each
// 32-bit word one by one as the output frees, and then finishes. The front
// end takes transfers into a 4-entry command queue whenever it has room, so
// the input side runs ahead while a query is being walked.
// ----------------------------------------------------------------------------
module missing_sequence_nack_tracker (
  input  logic                        clk,
  input  logic                        rst,
  // input transfers
  input  logic                        in_valid,
  output logic                        in_ready,
  input  mnt_pkg::in_item_t           in_data,
  // result transfers
  output logic                        out_valid,
  input  logic                        out_ready,
  output mnt_pkg::out_item_t          out_data,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mnt_pkg::PADDR_W-1:0] paddr,
  input  logic [mnt_pkg::PDATA_W-1:0] pwdata,
  output logic [mnt_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  // packet count of the transfer, register 0
  logic [mnt_pkg::SEQ_W-1:0] total_packets;
  logic                      reg_idx;

  // front to queue
  logic          push;
  mnt_pkg::cmd_t push_cmd;

  // queue to back
  mnt_pkg::cmd_t q_head;
  logic          q_empty;
  logic          q_full;
  logic          q_pop;

  // bitmap clearing finished
  logic map_ready;

  // register index from the word address, byte lanes ignored
  assign reg_idx = paddr[2];
  assign pready  = 1'b1;

  always_comb begin
    prdata = '0;
    if (reg_idx == mnt_pkg::REG_TOTAL_PACKETS) begin
      prdata = mnt_pkg::PDATA_W'(total_packets);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_packets <= mnt_pkg::TOTAL_RESET;
    end else if (psel && penable && pwrite && pready &&
                 reg_idx == mnt_pkg::REG_TOTAL_PACKETS) begin
      total_packets <= pwdata[mnt_pkg::SEQ_W-1:0];
    end
  end

  // front end: accepts transfers and works out each query's window
  mnt_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .total_packets (total_packets),
    .q_full        (q_full),
    .map_ready     (map_ready),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  // decouples the input side from the bitmap walk
  mnt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // back end: bitmap updates, query walk and the output register
  mnt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .map_ready (map_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
